@@ rtl/ksh_pkg.sv @@
// Shared types, constants and round function for the SipHash-2-4 engine.
// No dependencies; imported by every module of the block.
package ksh_pkg;

    // Full v0..v3 working state of the hash
    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } sip_state_t;

    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 8'd1;

    localparam logic [63:0] SIP_C0  = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1  = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2  = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3  = 64'h7465646279746573;
    localparam logic [63:0] SIP_FIN = 64'h00000000000000ff;
    localparam int          LEN_SHIFT = 56;
    localparam logic [7:0]  WORD_BYTES = 8'd8;

    // One SipRound; rotations are fixed wiring
    function automatic sip_state_t sip_mix_round(input sip_state_t s);
        sip_state_t  r;
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
        v0 = s.v0;
        v1 = s.v1;
        v2 = s.v2;
        v3 = s.v3;
        v0 = v0 + v1;
        v1 = {v1[50:0], v1[63:51]};
        v1 = v1 ^ v0;
        v0 = {v0[31:0], v0[63:32]};
        v2 = v2 + v3;
        v3 = {v3[47:0], v3[63:48]};
        v3 = v3 ^ v2;
        v0 = v0 + v3;
        v3 = {v3[42:0], v3[63:43]};
        v3 = v3 ^ v0;
        v2 = v2 + v1;
        v1 = {v1[46:0], v1[63:47]};
        v1 = v1 ^ v2;
        v2 = {v2[31:0], v2[63:32]};
        r.v0 = v0;
        r.v1 = v1;
        r.v2 = v2;
        r.v3 = v3;
        return r;
    endfunction

    function automatic sip_state_t sip_double_round(input sip_state_t s);
        return sip_mix_round(sip_mix_round(s));
    endfunction

endpackage

@@ rtl/ksh_absorb.sv @@
// Key registers, input register and message absorption (two rounds per word).
// Depends on ksh_pkg; feeds the finalization stages in ksh_final.
module ksh_absorb
    import ksh_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [63:0]            s_message_word,
    input  logic [2:0]             s_tail_bytes,
    input  logic                   s_is_last,
    output logic                   h_valid,
    input  logic                   h_ready,
    output sip_state_t             h_state
);

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;

    logic        in_valid_reg;
    logic [63:0] in_word_reg;
    logic [2:0]  in_tail_reg;
    logic        in_last_reg;

    sip_state_t  v_reg;
    logic [7:0]  length_count_reg;
    logic        in_message_reg;

    logic        h_valid_reg;
    sip_state_t  h_state_reg;
    sip_state_t  h_state_next;

    logic        h_free;
    logic        in_take;
    sip_state_t  v_start;
    sip_state_t  v_comp;
    sip_state_t  v_mixed;
    logic [7:0]  len_base;
    logic [7:0]  len_total;
    logic [63:0] tail_mask;
    logic [63:0] m_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_KEY_LOW) begin
                key_low_reg <= cfg_data;
            end
            if (cfg_index == CFG_KEY_HIGH) begin
                key_high_reg <= cfg_data;
            end
        end
    end

    // A last word needs room in the finalization stage; other words never wait
    assign h_free  = !h_valid_reg || h_ready;
    assign in_take = in_valid_reg && (!in_last_reg || h_free);
    assign s_ready = !in_valid_reg || in_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_message_word;
            in_tail_reg <= s_tail_bytes;
            in_last_reg <= s_is_last;
        end
    end

    always_comb begin
        // Reload from the key at message start
        if (in_message_reg) begin
            v_start  = v_reg;
            len_base = length_count_reg;
        end else begin
            v_start.v0 = key_low_reg ^ SIP_C0;
            v_start.v1 = key_high_reg ^ SIP_C1;
            v_start.v2 = key_low_reg ^ SIP_C2;
            v_start.v3 = key_high_reg ^ SIP_C3;
            len_base   = '0;
        end

        for (int i = 0; i < 8; i++) begin
            tail_mask[8*i +: 8] = (3'(i) < in_tail_reg) ? 8'hff : 8'h00;
        end
        len_total = len_base + {5'b0, in_tail_reg};

        // Tail word: masked bytes with the length byte on top
        if (in_last_reg) begin
            m_word = (in_word_reg & tail_mask) | ({56'b0, len_total} << LEN_SHIFT);
        end else begin
            m_word = in_word_reg;
        end

        v_mixed    = v_start;
        v_mixed.v3 = v_start.v3 ^ m_word;
        v_comp     = sip_double_round(v_mixed);
        v_comp.v0  = v_comp.v0 ^ m_word;
    end

    always_comb begin
        h_state_next    = v_comp;
        h_state_next.v2 = v_comp.v2 ^ SIP_FIN;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_message_reg   <= 1'b0;
            length_count_reg <= '0;
        end else if (in_take) begin
            in_message_reg   <= !in_last_reg;
            length_count_reg <= in_last_reg ? len_total : (len_base + WORD_BYTES);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            v_reg <= v_comp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
        end else if (h_free) begin
            h_valid_reg <= in_take && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (h_free && in_take && in_last_reg) begin
            h_state_reg <= h_state_next;
        end
    end

    assign h_valid = h_valid_reg;
    assign h_state = h_state_reg;

endmodule

@@ rtl/ksh_final.sv @@
// Finalization: four SipRounds over two stages, then the xor fold into the
// result register. Depends on ksh_pkg.
module ksh_final
    import ksh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        h_valid,
    output logic        h_ready,
    input  sip_state_t  h_state,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_value
);

    logic        f2_valid_reg;
    sip_state_t  f2_state_reg;
    logic        m_valid_reg;
    logic [63:0] m_hash_reg;

    logic        m_free;
    sip_state_t  v_fin;

    assign m_free  = !m_valid_reg || m_ready;
    assign h_ready = !f2_valid_reg || m_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_valid_reg <= 1'b0;
        end else if (h_ready) begin
            f2_valid_reg <= h_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (h_ready && h_valid) begin
            f2_state_reg <= sip_double_round(h_state);
        end
    end

    assign v_fin = sip_double_round(f2_state_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_free) begin
            m_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_free && f2_valid_reg) begin
            m_hash_reg <= v_fin.v0 ^ v_fin.v1 ^ v_fin.v2 ^ v_fin.v3;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

endmodule

@@ rtl/keyed_siphash_engine_core.sv @@
// SipHash-2-4 engine, top level: ties absorption and finalization together.
// Depends on ksh_pkg, ksh_absorb and ksh_final.
//
// Computes keyed SipHash-2-4. Load the key through the configuration channel
// (index 0 = key bytes 0..7, index 1 = key bytes 8..15, little-endian; other
// indexes are dropped) while no message is open. Send each message as full
// 8-byte words with s_is_last low, then one item with s_is_last high carrying
// the remaining 0 to 7 bytes, counted by s_tail_bytes. The engine takes one
// item per clock while no last item is held; each item is absorbed by two
// SipRounds in one combinational path, and that two-round path sets the clock
// limit. A hash passes the input, absorb hand-off, finalization stage and result
// registers before it shows on m_valid, and results come out in message order.
// Back pressure on m_ready holds a last item, and the input behind it, only once
// the three result stages are all full; full words ahead of it keep flowing.
module keyed_siphash_engine_core
    import ksh_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [63:0]            s_message_word,
    input  logic [2:0]             s_tail_bytes,
    input  logic                   s_is_last,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [63:0]            m_hash_value
);

    logic       h_valid;
    logic       h_ready;
    sip_state_t h_state;

    ksh_absorb u_absorb (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_word (s_message_word),
        .s_tail_bytes   (s_tail_bytes),
        .s_is_last      (s_is_last),
        .h_valid        (h_valid),
        .h_ready        (h_ready),
        .h_state        (h_state)
    );

    ksh_final u_final (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .h_valid      (h_valid),
        .h_ready      (h_ready),
        .h_state      (h_state),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

`ifndef SYNTHESIS
    // A stalled finalization hand-off must hold its state
    a_h_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        h_valid && !h_ready |=> h_valid && $stable(h_state))
        else $error("finalization hand-off changed while stalled");

    // Reset empties the pipeline and opens the input
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid && !h_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule

@@ verif/siphash_checker.sv @@
// Checker for the SipHash-2-4 engine: watches the key, message and hash channels.
// Keeps its own copy of the key and hash state, predicts each digest and compares.
// Depends on ksh_pkg for the state type, register indexes and constants.
module siphash_checker
    import ksh_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [63:0]            s_message_word,
    input  logic [2:0]             s_tail_bytes,
    input  logic                   s_is_last,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [63:0]            m_hash_value,
    output int                     mismatch_count,
    output int                     hashes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] key_lo;
    logic [63:0] key_hi;
    sip_state_t  hstate;
    logic [7:0]  byte_total;
    logic        msg_open;
    logic [63:0] digest_q[$];

    initial begin
        mismatch_count = 0;
        hashes_pending = 0;
    end

    function automatic logic [63:0] rot_left(input logic [63:0] x, input int s);
        return (x << s) | (x >> (64 - s));
    endfunction

    function automatic sip_state_t mix_round(input sip_state_t s);
        sip_state_t r;
        r = s;
        r.v0 = r.v0 + r.v1;
        r.v1 = rot_left(r.v1, 13);
        r.v1 = r.v1 ^ r.v0;
        r.v0 = rot_left(r.v0, 32);
        r.v2 = r.v2 + r.v3;
        r.v3 = rot_left(r.v3, 16);
        r.v3 = r.v3 ^ r.v2;
        r.v0 = r.v0 + r.v3;
        r.v3 = rot_left(r.v3, 21);
        r.v3 = r.v3 ^ r.v0;
        r.v2 = r.v2 + r.v1;
        r.v1 = rot_left(r.v1, 17);
        r.v1 = r.v1 ^ r.v2;
        r.v2 = rot_left(r.v2, 32);
        return r;
    endfunction

    function automatic sip_state_t absorb_word(input sip_state_t s, input logic [63:0] m);
        sip_state_t r;
        r = s;
        r.v3 = r.v3 ^ m;
        r = mix_round(mix_round(r));
        r.v0 = r.v0 ^ m;
        return r;
    endfunction

    task automatic note_mismatch(input logic [63:0] want, input logic [63:0] got,
                                 input bit orphan);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (orphan)
                $display("unexpected hash transfer: got %h", got);
            else
                $display("hash mismatch: expected %h got %h", want, got);
        end
    endtask

    always @(posedge aclk) begin : track
        logic [63:0] mask;
        logic [7:0]  total;
        logic [63:0] tail;
        logic [63:0] want;
        if (!aresetn) begin
            key_lo     = '0;
            key_hi     = '0;
            hstate     = '0;
            byte_total = '0;
            msg_open   = 1'b0;
            digest_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_KEY_LOW:  key_lo = cfg_data;
                    CFG_KEY_HIGH: key_hi = cfg_data;
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                // a new message picks up whatever key is loaded now
                if (!msg_open) begin
                    hstate.v0  = key_lo ^ SIP_C0;
                    hstate.v1  = key_hi ^ SIP_C1;
                    hstate.v2  = key_lo ^ SIP_C2;
                    hstate.v3  = key_hi ^ SIP_C3;
                    byte_total = '0;
                    msg_open   = 1'b1;
                end
                if (!s_is_last) begin
                    hstate     = absorb_word(hstate, s_message_word);
                    byte_total = byte_total + WORD_BYTES;
                end else begin
                    mask  = (s_tail_bytes == 3'd0) ? 64'd0 :
                            ({64{1'b1}} >> (64 - 8 * int'(s_tail_bytes)));
                    total = byte_total + {5'd0, s_tail_bytes};
                    tail  = (s_message_word & mask) | ({56'd0, total} << LEN_SHIFT);
                    hstate    = absorb_word(hstate, tail);
                    hstate.v2 = hstate.v2 ^ SIP_FIN;
                    hstate    = mix_round(mix_round(mix_round(mix_round(hstate))));
                    digest_q.push_back(hstate.v0 ^ hstate.v1 ^ hstate.v2 ^ hstate.v3);
                    byte_total = total;
                    msg_open   = 1'b0;
                end
            end

            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    note_mismatch('0, m_hash_value, 1'b1);
                end else begin
                    want = digest_q.pop_front();
                    if (want !== m_hash_value)
                        note_mismatch(want, m_hash_value, 1'b0);
                end
            end
        end
        hashes_pending = digest_q.size();
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for keyed_siphash_engine_core: clock, reset, key programming,
// directed and random message traffic with random idling on both channels.
// Depends on ksh_pkg, the engine RTL and siphash_checker.
module tb;
    import ksh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [63:0]            cfg_data       = '0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic [63:0]            s_message_word = '0;
    logic [2:0]             s_tail_bytes   = '0;
    logic                   s_is_last      = 1'b0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [63:0]            m_hash_value;

    int mismatch_count;
    int hashes_pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;

    always #5 aclk = ~aclk;

    keyed_siphash_engine_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_word (s_message_word),
        .s_tail_bytes   (s_tail_bytes),
        .s_is_last      (s_is_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_value   (m_hash_value)
    );

    siphash_checker u_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_word (s_message_word),
        .s_tail_bytes   (s_tail_bytes),
        .s_is_last      (s_is_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_value   (m_hash_value),
        .mismatch_count (mismatch_count),
        .hashes_pending (hashes_pending)
    );

    always @(posedge aclk)
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return {64{1'b1}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // hold valid and payload until the transfer; returns on the accepting edge
    task automatic send_item(input logic [63:0] word, input logic [2:0] nbytes,
                             input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_message_word <= word;
        s_tail_bytes   <= nbytes;
        s_is_last      <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (hashes_pending != 0);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // key writes only with no message open and the pipeline empty
    task automatic program_key(input logic [63:0] lo, input logic [63:0] hi);
        drain();
        repeat (8) @(posedge aclk);
        cfg_write(CFG_KEY_LOW, lo);
        cfg_write(CFG_KEY_HIGH, hi);
        // out-of-range index, must be dropped
        if ($urandom_range(0, 1))
            cfg_write({CFG_INDEX_W{1'b1}}, {$urandom, $urandom});
        else
            cfg_write(CFG_INDEX_W'($urandom_range(2, 254)), {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_message(input int nwords);
        for (int i = 0; i < nwords; i++)
            send_item(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
        send_item(pick_word(), 3'($urandom_range(0, 7)), 1'b1);
    endtask

    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        int phase_end;
        int nwords;
        logic [63:0] klo;
        logic [63:0] khi;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty message under the reset key, garbage above the tail masked off
        send_item({64{1'b1}}, 3'd0, 1'b1);

        program_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
        send_item(64'd0, 3'd0, 1'b1);
        send_item(64'hff06050403020100, 3'd7, 1'b1);
        send_item(64'h0706050403020100, 3'd5, 1'b0);
        send_item({64{1'b1}}, 3'd0, 1'b1);
        send_item(64'h0706050403020100, 3'd0, 1'b0);
        send_item(64'h000e0d0c0b0a0908, 3'd7, 1'b1);

        program_key({64{1'b1}}, {64{1'b1}});
        send_item({64{1'b1}}, 3'd2, 1'b0);
        send_item({64{1'b1}}, 3'd7, 1'b1);
        send_item(64'd0, 3'd1, 1'b1);

        program_key({64{1'b1}}, 64'd0);
        send_item(64'd0, 3'd7, 1'b0);
        send_item({64{1'b1}}, 3'd0, 1'b0);
        send_item(64'hfedcba9876543210, 3'd3, 1'b1);
        send_item(64'h0123456789abcdef, 3'd4, 1'b1);

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 63 : 0;
            recv_idle_pct = (mode == 0) ? 63 : (mode == 1) ? 6 : 0;
            for (int ks = 0; ks < 4; ks++) begin
                case (ks)
                    0:       begin klo = {$urandom, $urandom}; khi = {$urandom, $urandom}; end
                    1:       begin klo = {64{1'b1}};           khi = {64{1'b1}};           end
                    2:       begin klo = {64{1'b1}};           khi = 64'd0;                end
                    default: begin klo = 64'd0;                khi = 64'd0;                end
                endcase
                program_key(klo, khi);
                phase_end = items_sent + 112;
                while (items_sent < phase_end) begin
                    if ($urandom_range(0, 29) == 0)
                        drain();
                    // a few long messages wrap the byte count past 255
                    if ($urandom_range(0, 99) < 8)
                        nwords = $urandom_range(30, 40);
                    else
                        nwords = $urandom_range(0, 5);
                    send_message(nwords);
                end
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && hashes_pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ksh_pkg.sv
rtl/ksh_absorb.sv
rtl/ksh_final.sv
rtl/keyed_siphash_engine_core.sv
verif/siphash_checker.sv
verif/tb.sv
